[src/gated_spatial_recurrence_step_macros.svh]
// Assertion macros shared by the recurrence step RTL
`ifndef GATED_SPATIAL_RECURRENCE_STEP_MACROS_SVH
`define GATED_SPATIAL_RECURRENCE_STEP_MACROS_SVH
// check that a condition implies a consequence in the same cycle
`define GSR_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// check that a condition implies a consequence in the next cycle
`define GSR_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

[src/gsr_pkg.sv]
// Package with constants, types and helper functions for the recurrence step
package gsr_pkg;
  localparam int MAX_IN_CH  = 16;
  localparam int MAX_OUT_CH = 16;
  localparam int MAX_LINE   = 64;
  localparam int DW         = 16;
  localparam int ONE_Q      = 4096;
  localparam int ACC_W      = 48;

  localparam logic [2:0] CMD_WX   = 3'd0;
  localparam logic [2:0] CMD_WH   = 3'd1;
  localparam logic [2:0] CMD_BIAS = 3'd2;
  localparam logic [2:0] CMD_X    = 3'd3;
  localparam logic [2:0] CMD_GATE = 3'd4;

  localparam logic [2:0] REG_USE_BIAS = 3'd0;
  localparam logic [2:0] REG_USE_WX   = 3'd1;
  localparam logic [2:0] REG_USE_WH   = 3'd2;
  localparam logic [2:0] REG_ACT      = 3'd3;
  localparam logic [2:0] REG_GSCALE   = 3'd4;
  localparam logic [2:0] REG_WBOUND   = 3'd5;
  localparam logic [2:0] REG_IN_CH    = 3'd6;
  localparam logic [2:0] REG_OUT_CH   = 3'd7;

  localparam logic [1:0] ACT_LIN  = 2'd0;
  localparam logic [1:0] ACT_SIG  = 2'd1;
  localparam logic [1:0] ACT_RELU = 2'd2;
  localparam logic [1:0] ACT_TANH = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BIAS, ST_XW, ST_HW, ST_LNAR, ST_GATE, ST_GNAR, ST_PRE1,
    ST_PRE2, ST_ACT, ST_OUT, ST_WB
  } state_t;

  // round half up and saturate a Q.24 value to Q4.12
  function automatic logic signed [DW-1:0] narrow(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-13:0] q;
    begin
      t = v + ACC_W'(2048);
      q = t[ACC_W-1:12];
      if (q > (ACC_W-12)'(32767)) narrow = 16'sh7fff;
      else if (q < -(ACC_W-12)'(32768)) narrow = 16'sh8000;
      else narrow = q[DW-1:0];
    end
  endfunction

  function automatic logic [12:0] plan_sig(input logic signed [17:0] v);
    logic [17:0] y;
    logic [12:0] s;
    begin
      y = v[17] ? 18'(-v) : 18'(v);
      if (y >= 18'd20480) s = 13'd4096;
      else if (y >= 18'd9728) s = 13'(y >> 5) + 13'd3456;
      else if (y >= 18'd4096) s = 13'(y >> 3) + 13'd2560;
      else s = 13'(y >> 2) + 13'd2048;
      plan_sig = v[17] ? 13'd4096 - s : s;
    end
  endfunction
endpackage

[src/gated_spatial_recurrence_step.sv]
// Gated spatial recurrence step: one pixel, one shared multiply-accumulate unit.
// Commands 0..3 and non-final gate beats are stored on acceptance. The final gate
// beat runs a sequence per output channel of one bias step, in_channels Wx steps
// (one without input weights), out_channels Wh steps (one without history weights
// or history), a second such pass of Wx steps that forms XW alone, and six
// narrowing, gating, activation and output steps; the pixel then writes its
// out_channels results back as line history, one per cycle. The single multiplier
// serializes every product, and the output step stalls while a result waits in the
// output register until taken. The block is not ready for input while a pixel runs
// or a result waits.
module gated_spatial_recurrence_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // value[15:0], line_position[21:16], first_step[22], 0
  input  logic [10:0] in_tuser,   // command[2:0], row_index[6:3], channel_index[10:7]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_channel[3:0], hidden_value[19:4], 0
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [14:0] cfg_wdata
);
  import gsr_pkg::*;
  `include "gated_spatial_recurrence_step_macros.svh"

  logic use_bias_r, use_wx_r, use_wh_r;
  logic [1:0] act_r;
  logic [14:0] gscale_r, wbound_r;
  logic [4:0] in_ch_r, out_ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_bias_r <= 1'b1; use_wx_r <= 1'b1; use_wh_r <= 1'b1; act_r <= ACT_LIN;
      gscale_r <= 15'd4096; wbound_r <= '0; in_ch_r <= 5'd16; out_ch_r <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_USE_BIAS: use_bias_r <= cfg_wdata[0];
        REG_USE_WX:   use_wx_r <= cfg_wdata[0];
        REG_USE_WH:   use_wh_r <= cfg_wdata[0];
        REG_ACT:      act_r <= cfg_wdata[1:0];
        REG_GSCALE:   gscale_r <= cfg_wdata;
        REG_WBOUND:   wbound_r <= cfg_wdata;
        REG_IN_CH:    in_ch_r <= cfg_wdata[4:0];
        REG_OUT_CH:   out_ch_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  logic [2:0] cmd;
  logic [3:0] row, chn;
  logic [5:0] pos;
  logic first;
  logic signed [15:0] val;
  assign val = in_tdata[15:0];
  assign pos = in_tdata[21:16];
  assign first = in_tdata[22];
  assign cmd = in_tuser[2:0];
  assign row = in_tuser[6:3];
  assign chn = in_tuser[10:7];

  logic [4:0] n_in, n_out;
  assign n_in = (in_ch_r == 5'd0) ? 5'd1 : (in_ch_r > 5'd16 ? 5'd16 : in_ch_r);
  assign n_out = (out_ch_r == 5'd0) ? 5'd1 : (out_ch_r > 5'd16 ? 5'd16 : out_ch_r);

  logic signed [15:0] wx_mem [256];
  logic signed [15:0] wh_mem [256];
  logic signed [15:0] hist_mem [1024];
  logic signed [15:0] bias_a [16];
  logic signed [15:0] x_a [16];
  logic signed [15:0] g_a [16];
  logic signed [15:0] res_a [16];

  state_t state_r, state_nxt;
  logic [3:0] n_r, n_nxt;
  logic [4:0] k_r, k_nxt;
  logic [5:0] pos_r, pos_nxt;
  logic first_r, first_nxt;
  logic signed [15:0] l_r, l_nxt, p_r, p_nxt, g_r, g_nxt, pre_r, pre_nxt;
  logic signed [15:0] wx_q, wh_q, h_q;
  logic ovld_r, ovld_nxt, olast_r, olast_nxt;
  logic [3:0] och_r, och_nxt;
  logic signed [15:0] oval_r, oval_nxt;
  logic [3:0] rd_n;
  logic [3:0] rd_k;
  logic acc_w;
  logic hist_we;

  logic mac_clr, mac_en, mac_sub;
  logic signed [16:0] ma, mb;
  logic signed [ACC_W-1:0] acc;

  gsr_mac u_mac (.clk(clk), .clr(mac_clr), .en(mac_en), .sub(mac_sub), .a(ma), .b(mb),
                 .acc(acc));

  logic in_acc, trig;
  assign in_tready = (state_r == ST_IDLE) && !ovld_r;
  assign in_acc = in_tvalid && in_tready;
  assign trig = in_acc && cmd == CMD_GATE && {1'b0, chn} == n_out - 5'd1;

  // memory reads, addressed one step ahead of use, and the stores of commands and results
  always_ff @(posedge clk) begin
    wx_q <= wx_mem[{rd_k, rd_n}];
    wh_q <= wh_mem[{rd_k, rd_n}];
    h_q <= hist_mem[{(trig ? pos : pos_r), (use_wh_r ? rd_k : rd_n)}];
    if (in_acc && cmd == CMD_WX) wx_mem[{row, chn}] <= val;
    if (in_acc && cmd == CMD_WH) wh_mem[{row, chn}] <= val;
    if (in_acc && cmd == CMD_BIAS) bias_a[chn] <= val;
    if (in_acc && cmd == CMD_X) x_a[chn] <= val;
    if (in_acc && cmd == CMD_GATE) g_a[chn] <= val;
    if (acc_w) res_a[n_r] <= oval_nxt;
    if (hist_we) hist_mem[{pos_r, k_r[3:0]}] <= res_a[k_r[3:0]];
  end

  logic signed [15:0] whc;
  logic signed [15:0] bnd;
  logic signed [17:0] pre2;
  logic [12:0] sg;
  always_comb begin
    bnd = {1'b0, wbound_r};
    whc = wh_q;
    if (wbound_r != 15'd0) begin
      if (wh_q > bnd) whc = bnd;
      else if (wh_q < -bnd) whc = -bnd;
    end
    pre2 = (act_r == ACT_TANH) ? 18'(pre_r) <<< 1 : 18'(pre_r);
    sg = plan_sig(pre2);
  end

  always_comb begin
    state_nxt = state_r; n_nxt = n_r; k_nxt = k_r; pos_nxt = pos_r; first_nxt = first_r;
    l_nxt = l_r; p_nxt = p_r; g_nxt = g_r; pre_nxt = pre_r;
    ovld_nxt = ovld_r; olast_nxt = olast_r; och_nxt = och_r; oval_nxt = oval_r;
    mac_clr = 1'b0; mac_en = 1'b0; mac_sub = 1'b0; ma = '0; mb = '0;
    rd_n = n_r; rd_k = k_r[3:0]; acc_w = 1'b0; hist_we = 1'b0;
    if (ovld_r && out_tready) ovld_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (trig) begin
          state_nxt = ST_BIAS; n_nxt = '0; k_nxt = '0; pos_nxt = pos; first_nxt = first;
          rd_n = '0; rd_k = '0;
        end
      end
      ST_BIAS: begin
        mac_clr = 1'b1; mac_en = use_bias_r;
        ma = 17'(bias_a[n_r]); mb = 17'(ONE_Q);
        k_nxt = 5'd1; rd_k = 4'd1;
        if (use_wx_r) begin
          state_nxt = ST_XW; rd_k = '0; k_nxt = '0;
        end else state_nxt = ST_XW;
      end
      ST_XW: begin
        mac_sub = 1'b1;
        if (use_wx_r) begin
          mac_en = 1'b1; ma = 17'(x_a[k_r[3:0]]); mb = 17'(wx_q);
          rd_k = k_r[3:0] + 4'd1;
          k_nxt = k_r + 5'd1;
          if (k_r + 5'd1 == n_in) begin
            state_nxt = ST_HW; k_nxt = '0; rd_k = '0;
          end
        end else begin
          mac_en = {1'b0, n_r} < n_in; ma = 17'(x_a[n_r]); mb = 17'(ONE_Q);
          state_nxt = ST_HW; k_nxt = '0; rd_k = '0;
        end
      end
      ST_HW: begin
        if (first_r) state_nxt = ST_LNAR;
        else if (use_wh_r) begin
          mac_en = 1'b1; ma = 17'(h_q); mb = 17'(whc);
          rd_k = k_r[3:0] + 4'd1;
          k_nxt = k_r + 5'd1;
          if (k_r + 5'd1 == n_out) state_nxt = ST_LNAR;
        end else begin
          mac_en = 1'b1; ma = 17'(h_q); mb = 17'(ONE_Q);
          state_nxt = ST_LNAR;
        end
      end
      ST_LNAR: begin
        // hold L, then form XW alone for P
        l_nxt = narrow(acc);
        mac_clr = 1'b1; k_nxt = '0; rd_k = '0;
        state_nxt = ST_GATE;
      end
      ST_GATE: begin
        if (use_wx_r) begin
          mac_en = 1'b1; ma = 17'(x_a[k_r[3:0]]); mb = 17'(wx_q);
          rd_k = k_r[3:0] + 4'd1; k_nxt = k_r + 5'd1;
          if (k_r + 5'd1 == n_in) state_nxt = ST_GNAR;
        end else begin
          mac_en = {1'b0, n_r} < n_in; ma = 17'(x_a[n_r]); mb = 17'(ONE_Q);
          state_nxt = ST_GNAR;
        end
      end
      ST_GNAR: begin
        p_nxt = narrow(acc);
        mac_clr = 1'b1; mac_en = 1'b1; ma = 17'(g_a[n_r]); mb = 17'(signed'({1'b0, gscale_r}));
        state_nxt = ST_PRE1;
      end
      ST_PRE1: begin
        g_nxt = (gscale_r < 15'd4096) ? narrow(acc) : g_a[n_r];
        mac_clr = 1'b1; mac_en = 1'b1; ma = 17'(p_r); mb = 17'(signed'({1'b0, gscale_r}));
        state_nxt = ST_PRE2;
      end
      ST_PRE2: begin
        mac_en = 1'b1; ma = 17'(g_r); mb = 17'(l_r);
        state_nxt = ST_ACT;
      end
      ST_ACT: begin
        pre_nxt = narrow(acc);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ovld_r) begin
          case (act_r)
            ACT_SIG:  oval_nxt = 16'(sg);
            ACT_RELU: oval_nxt = pre_r[15] ? 16'sd0 : pre_r;
            ACT_TANH: oval_nxt = 16'(signed'({3'b0, sg}) * 2 - 4096);
            default:  oval_nxt = pre_r;
          endcase
          ovld_nxt = 1'b1; och_nxt = n_r; olast_nxt = {1'b0, n_r} == n_out - 5'd1;
          acc_w = 1'b1;
          n_nxt = n_r + 4'd1; k_nxt = '0; rd_n = n_r + 4'd1; rd_k = '0;
          state_nxt = olast_nxt ? ST_WB : ST_BIAS;
        end
      end
      ST_WB: begin
        hist_we = 1'b1; k_nxt = k_r + 5'd1;
        if (k_r + 5'd1 == n_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; ovld_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ovld_r <= ovld_nxt;
    end
    n_r <= n_nxt; k_r <= k_nxt; pos_r <= pos_nxt; first_r <= first_nxt;
    l_r <= l_nxt; p_r <= p_nxt; g_r <= g_nxt; pre_r <= pre_nxt;
    olast_r <= olast_nxt; och_r <= och_nxt; oval_r <= oval_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata = {4'd0, oval_r, och_r};
  assign out_tlast = olast_r;

  `GSR_ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_r != ST_IDLE, !in_tready)
  `GSR_ASSERT_NEXT(a_out_holds, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `GSR_ASSERT_IMP(a_trig_idle, clk, rst_n, trig, state_r == ST_IDLE)
endmodule

[src/gsr_mac.sv]
// Shared multiply-accumulate unit with a registered accumulator
module gsr_mac (
  input  logic                              clk,
  input  logic                              clr,
  input  logic                              en,
  input  logic                              sub,
  input  logic signed [16:0]                a,
  input  logic signed [16:0]                b,
  output logic signed [gsr_pkg::ACC_W-1:0]  acc
);
  import gsr_pkg::*;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, prod;
  logic signed [33:0] mul;
  assign mul = a * b;
  assign prod = ACC_W'(mul);
  always_comb begin
    acc_nxt = clr ? '0 : acc_r;
    if (en) acc_nxt = sub ? acc_nxt - prod : acc_nxt + prod;
  end
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end
  assign acc = acc_r;
endmodule
